/* sv/ptl_pkg.sv */
// Shared types and constants for the palindromic tree unit.
// No dependencies; the interfaces and the top level refer to this package by scoped names.
`default_nettype none

package ptl_pkg;

  localparam int FIELD_W   = 11;
  localparam int EVEN_ROOT = 0;
  localparam int ODD_ROOT  = 1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       new_string;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] suffix_pal_len;
    logic [FIELD_W-1:0] suffix_occurrences;
    logic [FIELD_W-1:0] best_len;
    logic [FIELD_W-1:0] best_end;
    logic               overflow;
  } out_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_WALK  = 9'b000000010,
    ST_WLEN  = 9'b000000100,
    ST_WCMP  = 9'b000001000,
    ST_CRD   = 9'b000010000,
    ST_CNODE = 9'b000100000,
    ST_CCHK  = 9'b001000000,
    ST_NEW   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

/* sv/ptl_in_if.sv */
// Input channel: one text byte per transfer with a restart flag.
// Depends on ptl_pkg for the payload type.
`default_nettype none

interface ptl_in_if;
  logic         valid;
  logic         ready;
  ptl_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/ptl_out_if.sv */
// Result channel: one result item per accepted byte.
// Depends on ptl_pkg for the payload type.
`default_nettype none

interface ptl_out_if;
  logic          valid;
  logic          ready;
  ptl_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/ptl_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No package dependencies.
`default_nettype none

module ptl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/palindromic_tree_longest_palindrome_unit.sv */
// Top level of the palindromic tree (eertree) unit: control sequencer and memories.
// Depends on ptl_pkg, ptl_in_if, ptl_out_if and ptl_ram.
//
//  channel | dir | payload                                              | transfer
//  item    | in  | symbol[7:0], new_string                              | valid & ready
//  result  | out | suffix_pal_len, suffix_occurrences, best_len,        | valid & ready
//          |     | best_end (11 bits each), overflow                    |
//
// Order: take the byte; each node tried by a walk gets a record read, a length step
// and a text compare, skipped for a node too long to extend inside the text; a walk
// ends at the odd root. The lookup reads the child table, then the node record,
// checked when in range. Unless it extends the odd root, a new node repeats walk
// and lookup for its suffix link, then is written; then hand off. A byte past a
// full text goes straight to hand-off. One read port per memory sets this order.
// Reset: clears control state only; no memory sweep, since a child entry counts
// only when the node it names is in range and records this parent and symbol.
// Stalls: a finished result waits in the output register while the next byte is
// taken; the unit holds in ST_FIN only if that register is still occupied.
`default_nettype none

module palindromic_tree_longest_palindrome_unit #(
  parameter int MAX_TEXT = 1024,
  parameter int ALPHABET = 256
) (
  input wire logic  clk,
  input wire logic  rst,
  ptl_in_if.sink    item,
  ptl_out_if.source result
);

  localparam int NODE_CAP = MAX_TEXT + 2;
  localparam int PW       = $clog2(MAX_TEXT + 1);
  localparam int NW       = $clog2(NODE_CAP);
  localparam int AW       = $clog2(ALPHABET);
  localparam int CDEPTH   = NODE_CAP * ALPHABET;
  localparam int CW       = $clog2(CDEPTH);
  localparam int REC_W    = PW + NW + PW + NW + AW;
  localparam int FW       = ptl_pkg::FIELD_W;

  localparam logic [NW-1:0] EVEN = NW'(ptl_pkg::EVEN_ROOT);
  localparam logic [NW-1:0] ODD  = NW'(ptl_pkg::ODD_ROOT);

  // Reduce a byte modulo the alphabet size, one bit per step.
  function automatic logic [AW-1:0] sym_mod(input logic [7:0] s);
    logic [9:0] r;
    r = '0;
    for (int b = 7; b >= 0; b--) begin
      r = {r[8:0], s[b]};
      if (r >= 10'(ALPHABET)) begin
        r = r - 10'(ALPHABET);
      end
    end
    return AW'(r);
  endfunction

  ptl_pkg::state_t state;

  logic [PW-1:0] pos, longest_len, longest_end;
  logic [NW-1:0] node_total, last_node;
  logic [NW-1:0] v, key, f, flink, n_reg, new_link, link_v;
  logic [PW-1:0] len_v, f_len;
  logic          mode;              // 0: main walk, 1: suffix link walk
  logic [AW-1:0] c;
  logic [PW-1:0] res_len, res_hits;
  logic          res_ovf;
  logic          out_valid;
  ptl_pkg::out_t out_data;

  // Memory ports
  logic             text_we;
  logic [PW-1:0]    text_waddr, text_raddr;
  logic [AW-1:0]    text_wdata, text_rdata;
  logic             node_we;
  logic [NW-1:0]    node_waddr, node_raddr;
  logic [REC_W-1:0] node_wdata, node_rdata;
  logic             child_we;
  logic [CW-1:0]    child_waddr, child_raddr;
  logic [NW-1:0]    child_wdata, child_rdata;

  ptl_ram #(.WIDTH(AW), .DEPTH(MAX_TEXT + 1)) u_text (
    .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(text_wdata),
    .raddr(text_raddr), .rdata(text_rdata)
  );

  ptl_ram #(.WIDTH(REC_W), .DEPTH(NODE_CAP)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  ptl_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_rdata)
  );

  // Node record fields: length, suffix link, hits, parent, symbol.
  logic [PW-1:0] rd_len, rd_hits;
  logic [NW-1:0] rd_link, rd_parent;
  logic [AW-1:0] rd_sym;
  assign {rd_len, rd_link, rd_hits, rd_parent, rd_sym} = node_rdata;

  logic [AW-1:0] sym_c;
  logic [PW-1:0] pos_cur;
  logic [PW-1:0] lv;
  logic [NW-1:0] lk;
  logic          hit_range, rec_match, miss_to_walk, upd;
  logic [NW-1:0] new_id;
  logic [PW-1:0] new_len;
  logic [CW-1:0] key_addr, f_addr;

  assign sym_c        = sym_mod(item.data.symbol);
  assign pos_cur      = item.data.new_string ? '0 : pos;
  assign lv           = (v == EVEN) ? '0 : rd_len;
  assign lk           = (v == EVEN) ? ODD : rd_link;
  assign hit_range    = (child_rdata >= NW'(2)) && (child_rdata <= node_total);
  assign rec_match    = (rd_parent == key) && (rd_sym == c);
  assign miss_to_walk = !mode && (f != ODD);
  assign new_id       = node_total + NW'(1);
  assign new_len      = (f == ODD) ? PW'(1) : f_len + PW'(2);
  assign key_addr     = CW'(key) * CW'(ALPHABET) + CW'(c);
  assign f_addr       = CW'(f) * CW'(ALPHABET) + CW'(c);
  assign upd          = !res_ovf && (res_len > longest_len);

  assign item.ready   = (state == ptl_pkg::ST_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Memory control: reads are issued in the state before the one that uses them.
  // Writes never target an entry read in the same item's pending cycles.
  always_comb begin
    text_we     = 1'b0;
    text_waddr  = pos_cur + PW'(1);
    text_wdata  = sym_c;
    text_raddr  = pos - lv - PW'(1);
    node_we     = 1'b0;
    node_waddr  = new_id;
    node_wdata  = {new_len, new_link, PW'(1), f, c};
    node_raddr  = v;
    child_we    = 1'b0;
    child_waddr = f_addr;
    child_wdata = new_id;
    child_raddr = key_addr;
    unique case (state)
      ptl_pkg::ST_IDLE: begin
        text_we = item.valid && (pos_cur < PW'(MAX_TEXT));
      end
      ptl_pkg::ST_CNODE: begin
        node_raddr = child_rdata;
      end
      ptl_pkg::ST_CCHK: begin
        // Existing node on the main lookup: bump its hit count.
        node_we    = rec_match && !mode;
        node_waddr = n_reg;
        node_wdata = {rd_len, rd_link, rd_hits + PW'(1), rd_parent, rd_sym};
      end
      ptl_pkg::ST_NEW: begin
        node_we  = 1'b1;
        child_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ptl_pkg::ST_IDLE;
      node_total  <= ODD;
      last_node   <= EVEN;
      pos         <= '0;
      longest_len <= '0;
      longest_end <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Drop the held result once taken, unless ST_FIN refills it this cycle.
      if (out_valid && result.ready && (state != ptl_pkg::ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ptl_pkg::ST_IDLE: begin
          if (item.valid) begin
            c <= sym_c;
            if (item.data.new_string) begin
              node_total  <= ODD;
              last_node   <= EVEN;
              longest_len <= '0;
              longest_end <= '0;
            end
            if (pos_cur >= PW'(MAX_TEXT)) begin
              // Text full: drop the byte and report overflow.
              pos      <= pos_cur;
              res_len  <= '0;
              res_hits <= '0;
              res_ovf  <= 1'b1;
              state    <= ptl_pkg::ST_FIN;
            end else begin
              pos     <= pos_cur + PW'(1);
              v       <= item.data.new_string ? EVEN : last_node;
              mode    <= 1'b0;
              res_ovf <= 1'b0;
              state   <= ptl_pkg::ST_WALK;
            end
          end
        end
        ptl_pkg::ST_WALK: begin
          if (v == ODD) begin
            key <= ODD;
            if (!mode) begin
              f     <= ODD;
              f_len <= '0;
              flink <= ODD;
            end
            state <= ptl_pkg::ST_CRD;
          end else begin
            state <= ptl_pkg::ST_WLEN;
          end
        end
        ptl_pkg::ST_WLEN: begin
          len_v  <= lv;
          link_v <= lk;
          // Compare only when the mirrored byte lies in the text, past the sentinel.
          if (pos > lv + PW'(1)) begin
            state <= ptl_pkg::ST_WCMP;
          end else begin
            v     <= lk;
            state <= ptl_pkg::ST_WALK;
          end
        end
        ptl_pkg::ST_WCMP: begin
          if (text_rdata == c) begin
            key <= v;
            if (!mode) begin
              f     <= v;
              f_len <= len_v;
              flink <= link_v;
            end
            state <= ptl_pkg::ST_CRD;
          end else begin
            v     <= link_v;
            state <= ptl_pkg::ST_WALK;
          end
        end
        ptl_pkg::ST_CRD: begin
          state <= ptl_pkg::ST_CNODE;
        end
        ptl_pkg::ST_CNODE: begin
          n_reg <= child_rdata;
          if (hit_range) begin
            state <= ptl_pkg::ST_CCHK;
          end else if (miss_to_walk) begin
            mode  <= 1'b1;
            v     <= flink;
            state <= ptl_pkg::ST_WALK;
          end else begin
            new_link <= EVEN;
            state    <= ptl_pkg::ST_NEW;
          end
        end
        ptl_pkg::ST_CCHK: begin
          if (rec_match && !mode) begin
            res_len   <= rd_len;
            res_hits  <= rd_hits + PW'(1);
            last_node <= n_reg;
            state     <= ptl_pkg::ST_FIN;
          end else if (rec_match) begin
            new_link <= n_reg;
            state    <= ptl_pkg::ST_NEW;
          end else if (miss_to_walk) begin
            mode  <= 1'b1;
            v     <= flink;
            state <= ptl_pkg::ST_WALK;
          end else begin
            new_link <= EVEN;
            state    <= ptl_pkg::ST_NEW;
          end
        end
        ptl_pkg::ST_NEW: begin
          node_total <= new_id;
          last_node  <= new_id;
          res_len    <= new_len;
          res_hits   <= PW'(1);
          state      <= ptl_pkg::ST_FIN;
        end
        ptl_pkg::ST_FIN: begin
          if (!out_valid || result.ready) begin
            out_valid                   <= 1'b1;
            out_data.suffix_pal_len     <= FW'(res_len);
            out_data.suffix_occurrences <= FW'(res_hits);
            out_data.best_len           <= FW'(upd ? res_len : longest_len);
            out_data.best_end           <= FW'(upd ? pos : longest_end);
            out_data.overflow           <= res_ovf;
            if (upd) begin
              longest_len <= res_len;
              longest_end <= pos;
            end
            state <= ptl_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ptl_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // At most one node per stored byte beyond the roots.
  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    (NW + 1)'(node_total) <= (NW + 1)'(pos) + (NW + 1)'(1))
    else $error("node count exceeds stored text");

  // The recorded longest palindrome ends inside the stored text.
  a_end_bound: assert property (@(posedge clk) disable iff (rst)
    (longest_end <= pos) && (longest_len <= longest_end))
    else $error("longest palindrome outside text");

  // A result appears only on the hand-off from ST_FIN.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ptl_pkg::ST_FIN))
    else $error("result raised outside hand-off");

endmodule

`default_nettype wire
